### rtl/interval_set_engine_defines.svh
// Assertion macros shared by the interval set engine RTL.
`ifndef INTERVAL_SET_ENGINE_DEFINES_SVH
`define INTERVAL_SET_ENGINE_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define ISE_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define ISE_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/iset_pkg.sv
// Package with shared constants and codes of the interval set engine.
`default_nettype none
package iset_pkg;
   localparam int DEF_MAX_RANGES = 32;
   localparam int DEF_ID_BITS    = 16;

   localparam logic [1:0] MODE_ADD   = 2'd0;
   localparam logic [1:0] MODE_DEL   = 2'd1;
   localparam logic [1:0] MODE_QUERY = 2'd2;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;
endpackage
`default_nettype wire

### rtl/iset_ram.sv
// Generic single write port RAM with a registered read port.
`default_nettype none
module iset_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end
endmodule
`default_nettype wire

### rtl/interval_set_engine.sv
// Top level of the interval set engine: sequencer, table banks and result register.
// Each entry is read through the registered read port of the live bank in S_READ and
// handled in S_PROC, so one request is worked on at a time and a new one is taken only
// back in idle; the receiver cannot stall. Reset clears the table count and total at once.
`default_nettype none
`include "interval_set_engine_defines.svh"
module interval_set_engine
   import iset_pkg::*;
#(
   parameter int MAX_RANGES = DEF_MAX_RANGES,
   parameter int ID_BITS    = DEF_ID_BITS
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   output logic                                     busy,
   input  wire logic [1:0]                          req_mode,
   input  wire logic [ID_BITS-1:0]                  req_lo,
   input  wire logic [ID_BITS:0]                    req_hi,
   output logic                                     rsp_valid,
   output logic [1:0]                               rsp_status,
   output logic                                     rsp_member,
   output logic [ID_BITS:0]                         rsp_rank,
   output logic [ID_BITS:0]                         rsp_total,
   output logic [$clog2(MAX_RANGES+1)-1:0]          rsp_ranges_used
);
   localparam int IDX_W = $clog2(MAX_RANGES);
   localparam int CNT_W = $clog2(MAX_RANGES + 1);
   localparam int KW    = $clog2(MAX_RANGES + 2);
   localparam int DW    = 2 * ID_BITS + 1;

   // The sequencer walks the live bank one entry at a time and rebuilds the
   // table into the other bank; the banks swap only when the rebuild fits.
   typedef enum logic [2:0] {
      S_IDLE, S_READ, S_PROC, S_PUSH2, S_FINAL, S_DONE
   } state_type;

   state_type state_ff, state_in;
   logic [1:0]         mode_ff, mode_in;
   logic [ID_BITS-1:0] lo_ff, lo_in;
   logic [ID_BITS:0]   hi_ff, hi_in;
   logic [CNT_W-1:0]   idx_ff, idx_in;
   logic [KW-1:0]      k_ff, k_in;
   logic               placed_ff, placed_in;
   logic [ID_BITS:0]   ns_ff, ns_in, ne_ff, ne_in;
   logic [ID_BITS:0]   pend_s_ff, pend_s_in, pend_e_ff, pend_e_in;
   logic [ID_BITS:0]   ntot_ff, ntot_in;
   logic [ID_BITS:0]   rank_ff, rank_in;
   logic               member_ff, member_in;
   logic [1:0]         status_ff, status_in;
   logic               bank_ff, bank_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [ID_BITS:0]   total_ff, total_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [1:0]         rsp_status_ff, rsp_status_in;
   logic               rsp_member_ff, rsp_member_in;
   logic [ID_BITS:0]   rsp_rank_ff, rsp_rank_in;
   logic [ID_BITS:0]   rsp_total_ff, rsp_total_in;
   logic [CNT_W-1:0]   rsp_used_ff, rsp_used_in;

   logic [DW-1:0]      q0, q1, rd_word, wdata;
   logic [ID_BITS:0]   rd_s, rd_e;
   logic               wr_req, we;
   logic [ID_BITS:0]   wr_s, wr_e;
   logic [ID_BITS:0]   lo_x, left_end, right_beg, q_sub;
   logic               a_v, b_v, last;
   logic [ID_BITS:0]   a_s, a_e, b_s, b_e;

   assign rd_word = bank_ff ? q1 : q0;
   assign rd_s    = {1'b0, rd_word[DW-1 -: ID_BITS]};
   assign rd_e    = rd_word[ID_BITS:0];
   assign lo_x    = {1'b0, lo_ff};
   assign wdata   = {wr_s[ID_BITS-1:0], wr_e};
   assign we      = wr_req && (k_ff < KW'(MAX_RANGES));

   iset_ram #(.WIDTH(DW), .DEPTH(MAX_RANGES)) u_bank0 (
      .clock(clock), .we(we && bank_ff), .waddr(k_ff[IDX_W-1:0]), .wdata(wdata),
      .raddr(idx_ff[IDX_W-1:0]), .rdata(q0)
   );
   iset_ram #(.WIDTH(DW), .DEPTH(MAX_RANGES)) u_bank1 (
      .clock(clock), .we(we && !bank_ff), .waddr(k_ff[IDX_W-1:0]), .wdata(wdata),
      .raddr(idx_ff[IDX_W-1:0]), .rdata(q1)
   );

   always_comb begin
      state_in = state_ff;   mode_in = mode_ff;     lo_in = lo_ff;       hi_in = hi_ff;
      idx_in = idx_ff;       k_in = k_ff;           placed_in = placed_ff;
      ns_in = ns_ff;         ne_in = ne_ff;         pend_s_in = pend_s_ff;
      pend_e_in = pend_e_ff; ntot_in = ntot_ff;     rank_in = rank_ff;
      member_in = member_ff; status_in = status_ff; bank_in = bank_ff;
      count_in = count_ff;   total_in = total_ff;
      rsp_valid_in = 1'b0;   rsp_status_in = rsp_status_ff;
      rsp_member_in = rsp_member_ff; rsp_rank_in = rsp_rank_ff;
      rsp_total_in = rsp_total_ff;   rsp_used_in = rsp_used_ff;
      wr_req = 1'b0; wr_s = '0; wr_e = '0;
      a_v = 1'b0; a_s = '0; a_e = '0; b_v = 1'b0; b_s = '0; b_e = '0;
      left_end  = (rd_e < lo_x) ? rd_e : lo_x;
      right_beg = (rd_s > hi_ff) ? rd_s : hi_ff;
      q_sub     = ((rd_e <= lo_x) ? rd_e : lo_x) - rd_s;
      last      = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               mode_in = req_mode; lo_in = req_lo; hi_in = req_hi;
               idx_in = '0; k_in = '0; placed_in = 1'b0;
               ns_in = {1'b0, req_lo}; ne_in = req_hi; ntot_in = '0;
               rank_in = '0; member_in = 1'b0; status_in = ST_OK;
               if ((req_mode == MODE_ADD || req_mode == MODE_DEL) &&
                   (req_hi <= {1'b0, req_lo})) begin
                  status_in = ST_EMPTY;
                  state_in  = S_DONE;
               end else if (req_mode != MODE_ADD && req_mode != MODE_DEL &&
                            req_mode != MODE_QUERY) begin
                  state_in = S_DONE;
               end else if (count_ff == '0) begin
                  state_in = (req_mode == MODE_ADD) ? S_FINAL : S_DONE;
               end else begin
                  state_in = S_READ;
               end
            end
         end
         S_READ: begin
            state_in = S_PROC;
         end
         S_PROC: begin
            if (mode_ff == MODE_ADD) begin
               if (rd_e < lo_x) begin
                  a_v = 1'b1; a_s = rd_s; a_e = rd_e;
               end else if (rd_s > hi_ff) begin
                  if (!placed_ff) begin
                     a_v = 1'b1; a_s = ns_ff; a_e = ne_ff;
                     b_v = 1'b1; b_s = rd_s;  b_e = rd_e;
                     placed_in = 1'b1;
                  end else begin
                     a_v = 1'b1; a_s = rd_s; a_e = rd_e;
                  end
               end else begin
                  if (rd_s < ns_ff) ns_in = rd_s;
                  if (rd_e > ne_ff) ne_in = rd_e;
               end
            end else if (mode_ff == MODE_DEL) begin
               if (rd_s < left_end) begin
                  a_v = 1'b1; a_s = rd_s; a_e = left_end;
                  if (right_beg < rd_e) begin
                     b_v = 1'b1; b_s = right_beg; b_e = rd_e;
                  end
               end else if (right_beg < rd_e) begin
                  a_v = 1'b1; a_s = right_beg; a_e = rd_e;
               end
            end else begin
               if (rd_e <= lo_x || rd_s <= lo_x) begin
                  rank_in = rank_ff + q_sub;
               end
               if (rd_e > lo_x && rd_s <= lo_x) begin
                  member_in = 1'b1;
               end
            end
            wr_req = a_v; wr_s = a_s; wr_e = a_e;
            pend_s_in = b_s; pend_e_in = b_e;
            idx_in = idx_ff + 1'b1;
            last = (idx_ff + 1'b1 == count_ff);
            if (b_v) begin
               state_in = S_PUSH2;
            end else if (last) begin
               state_in = (mode_ff == MODE_ADD) ? S_FINAL : S_DONE;
            end else begin
               state_in = S_READ;
            end
         end
         S_PUSH2: begin
            wr_req = 1'b1; wr_s = pend_s_ff; wr_e = pend_e_ff;
            if (idx_ff == count_ff) begin
               state_in = (mode_ff == MODE_ADD) ? S_FINAL : S_DONE;
            end else begin
               state_in = S_READ;
            end
         end
         S_FINAL: begin
            wr_req = !placed_ff; wr_s = ns_ff; wr_e = ne_ff;
            state_in = S_DONE;
         end
         S_DONE: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = status_ff;
            rsp_member_in = 1'b0;
            rsp_rank_in   = '0;
            rsp_total_in  = total_ff;
            rsp_used_in   = count_ff;
            if ((mode_ff == MODE_ADD || mode_ff == MODE_DEL) && status_ff == ST_OK) begin
               if (k_ff <= KW'(MAX_RANGES)) begin
                  bank_in      = !bank_ff;
                  count_in     = k_ff[CNT_W-1:0];
                  total_in     = ntot_ff;
                  rsp_total_in = ntot_ff;
                  rsp_used_in  = k_ff[CNT_W-1:0];
               end else begin
                  rsp_status_in = ST_FULL;
               end
            end else if (mode_ff == MODE_QUERY) begin
               rsp_member_in = member_ff;
               rsp_rank_in   = rank_ff;
            end
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Each written entry advances the fill index, saturating one past capacity
      // so an overflowing rebuild is recognized at commit.
      if (wr_req) begin
         if (k_ff != KW'(MAX_RANGES + 1)) begin
            k_in = k_ff + 1'b1;
         end
         ntot_in = ntot_ff + (wr_e - wr_s);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         bank_ff      <= 1'b0;
         count_ff     <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         bank_ff      <= bank_in;
         count_ff     <= count_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mode_ff <= mode_in;     lo_ff <= lo_in;         hi_ff <= hi_in;
      idx_ff <= idx_in;       k_ff <= k_in;           placed_ff <= placed_in;
      ns_ff <= ns_in;         ne_ff <= ne_in;         pend_s_ff <= pend_s_in;
      pend_e_ff <= pend_e_in; ntot_ff <= ntot_in;     rank_ff <= rank_in;
      member_ff <= member_in; status_ff <= status_in;
      rsp_status_ff <= rsp_status_in; rsp_member_ff <= rsp_member_in;
      rsp_rank_ff <= rsp_rank_in;     rsp_total_ff <= rsp_total_in;
      rsp_used_ff <= rsp_used_in;
   end

   assign busy            = (state_ff != S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_member      = rsp_member_ff;
   assign rsp_rank        = rsp_rank_ff;
   assign rsp_total       = rsp_total_ff;
   assign rsp_ranges_used = rsp_used_ff;

   // A result is shown only once the sequencer has gone back to idle.
   `ISE_ASSERT_IMP(a_rsp_idle, clock, reset, rsp_valid, !busy, "result while busy")
   // An accepted transaction always occupies the sequencer.
   `ISE_ASSERT_NXT(a_start_busy, clock, reset, start && !busy, busy, "start not taken")
   // The table never holds more ranges than it has room for.
   `ISE_ASSERT_IMP(a_count_cap, clock, reset, 1'b1, count_ff <= CNT_W'(MAX_RANGES),
                   "count overflow")
   // A full report comes only from a table already at capacity.
   `ISE_ASSERT_IMP(a_full_cap, clock, reset, rsp_valid && rsp_status == ST_FULL,
                   rsp_ranges_used == CNT_W'(MAX_RANGES), "full with room left")
endmodule
`default_nettype wire

### verif/tb_interval_set_engine.sv
// Self-checking testbench for the interval set engine: add, delete and rank queries.
`timescale 1ns / 100ps
`default_nettype none
module tb_interval_set_engine;
   import iset_pkg::*;

   localparam int NRANGE = DEF_MAX_RANGES;
   localparam int IDW    = DEF_ID_BITS;
   localparam int CYCLE_LIMIT = 400000;

   // One request transaction as it is driven onto the request ports.
   typedef struct packed {
      logic [1:0]     mode;
      logic [IDW-1:0] lo;
      logic [IDW:0]   hi;
   } op_type;

   // One response transaction as the engine should present it.
   typedef struct packed {
      logic [1:0]                      status;
      logic                            member;
      logic [IDW:0]                    rank;
      logic [IDW:0]                    total;
      logic [$clog2(NRANGE+1)-1:0]     used;
   } answer_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic [1:0] req_mode = '0;
   logic [IDW-1:0] req_lo = '0;
   logic [IDW:0] req_hi = '0;
   wire busy;
   wire rsp_valid;
   wire [1:0] rsp_status;
   wire rsp_member;
   wire [IDW:0] rsp_rank;
   wire [IDW:0] rsp_total;
   wire [$clog2(NRANGE+1)-1:0] rsp_ranges_used;

   interval_set_engine dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_mode(req_mode), .req_lo(req_lo), .req_hi(req_hi),
      .rsp_valid(rsp_valid), .rsp_status(rsp_status), .rsp_member(rsp_member),
      .rsp_rank(rsp_rank), .rsp_total(rsp_total), .rsp_ranges_used(rsp_ranges_used)
   );

   always #5 clock = ~clock;

   // Shadow copy of the range table, kept sorted and disjoint like the engine's.
   int unsigned shadow_start[NRANGE];
   int unsigned shadow_stop[NRANGE];
   int unsigned shadow_count = 0;

   op_type     pending_ops[$];
   answer_type expected_answers[$];
   int      error_count = 0;
   int      answers_seen = 0;
   int      accepted_ops = 0;
   int      cycle_count = 0;
   int      send_idle_pct = 30;
   bit      stimulus_done = 1'b0;

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch at cycle %0d on response %0d: %s got %0d expected %0d",
               cycle_count, answers_seen, what, got, want);
      error_count++;
   endtask

   // Applies one operation to the shadow table and returns the response it should cause.
   // New contents are built in a scratch list, committed only if they fit the table.
   function automatic answer_type apply_op(input op_type op);
      answer_type ans;
      int unsigned lo, hi, s, e, ns, ne, k, i, tot, rnk;
      int unsigned scratch_start[NRANGE+2];
      int unsigned scratch_stop[NRANGE+2];
      bit placed, mem;
      lo = op.lo;
      hi = op.hi;
      k = 0;
      placed = 1'b0;
      ans = '0;
      if ((op.mode == MODE_ADD || op.mode == MODE_DEL) && hi <= lo) begin
         ans.status = ST_EMPTY;
      end else if (op.mode == MODE_ADD) begin
         ns = lo;
         ne = hi;
         for (i = 0; i < shadow_count; i++) begin
            s = shadow_start[i];
            e = shadow_stop[i];
            if (e < lo) begin
               scratch_start[k] = s; scratch_stop[k] = e; k++;
            end else if (s > hi) begin
               if (!placed) begin
                  scratch_start[k] = ns; scratch_stop[k] = ne; k++;
                  placed = 1'b1;
               end
               scratch_start[k] = s; scratch_stop[k] = e; k++;
            end else begin
               // Overlapping or touching entries fold into the new range.
               if (s < ns) ns = s;
               if (e > ne) ne = e;
            end
         end
         if (!placed) begin
            scratch_start[k] = ns; scratch_stop[k] = ne; k++;
         end
      end else if (op.mode == MODE_DEL) begin
         for (i = 0; i < shadow_count; i++) begin
            s = shadow_start[i];
            e = shadow_stop[i];
            // Keep the part left of the hole and the part right of it, if any.
            if (s < ((e < lo) ? e : lo)) begin
               scratch_start[k] = s; scratch_stop[k] = (e < lo) ? e : lo; k++;
            end
            if (((s > hi) ? s : hi) < e) begin
               scratch_start[k] = (s > hi) ? s : hi; scratch_stop[k] = e; k++;
            end
         end
      end
      if (ans.status != ST_EMPTY && (op.mode == MODE_ADD || op.mode == MODE_DEL)) begin
         if (k > NRANGE) begin
            ans.status = ST_FULL;
         end else begin
            for (i = 0; i < k; i++) begin
               shadow_start[i] = scratch_start[i];
               shadow_stop[i] = scratch_stop[i];
            end
            shadow_count = k;
         end
      end
      tot = 0;
      rnk = 0;
      mem = 1'b0;
      for (i = 0; i < shadow_count; i++) begin
         s = shadow_start[i];
         e = shadow_stop[i];
         tot += e - s;
         if (op.mode == MODE_QUERY) begin
            if (e <= lo) rnk += e - s;
            else if (s <= lo) begin
               mem = 1'b1;
               rnk += lo - s;
            end
         end
      end
      ans.member = mem;
      ans.rank = rnk;
      ans.total = tot;
      ans.used = shadow_count;
      return ans;
   endfunction

   function automatic op_type make_op(input logic [1:0] mode, input int unsigned lo,
                                      input int unsigned hi);
      op_type op;
      op.mode = mode;
      op.lo = lo;
      op.hi = hi;
      return op;
   endfunction

   // Driver: a transaction is taken at an edge where start is high and busy is low.
   // start is only ever changed after such an edge or while it is low, so it is
   // assigned at most once per edge.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset) begin
         if (start && !busy) begin
            expected_answers.push_back(apply_op({req_mode, req_lo, req_hi}));
            accepted_ops <= accepted_ops + 1;
            if (pending_ops.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               {req_mode, req_lo, req_hi} <= pending_ops.pop_front();
            end else begin
               start <= 1'b0;
            end
         end else if (!start && pending_ops.size() > 0
                      && $urandom_range(99) >= send_idle_pct) begin
            {req_mode, req_lo, req_hi} <= pending_ops.pop_front();
            start <= 1'b1;
         end
      end
   end

   // Monitor: each strobed response is compared with the oldest expectation.
   always @(posedge clock) begin
      answer_type want;
      if (!reset && rsp_valid) begin
         answers_seen <= answers_seen + 1;
         if (expected_answers.size() == 0) begin
            report_mismatch("response with nothing expected, status", rsp_status, 0);
         end else begin
            want = expected_answers.pop_front();
            if (rsp_status !== want.status)
               report_mismatch("status", rsp_status, want.status);
            if (rsp_member !== want.member)
               report_mismatch("member", rsp_member, want.member);
            if (rsp_rank !== want.rank)
               report_mismatch("rank", rsp_rank, want.rank);
            if (rsp_total !== want.total)
               report_mismatch("total", rsp_total, want.total);
            if (rsp_ranges_used !== want.used)
               report_mismatch("ranges_used", rsp_ranges_used, want.used);
         end
      end
   end

   // Random range whose ends cluster around a small id window so that merges,
   // splits and a full table happen often; sometimes the whole id space is used.
   task automatic queue_random(input int count);
      int unsigned lo, hi, span, base, sel, window;
      for (int n = 0; n < count; n++) begin
         sel = $urandom_range(99);
         window = ($urandom_range(3) == 0) ? 65535 : 1023;
         base = ($urandom_range(1) == 0) ? 0 : $urandom_range(65535 - window);
         lo = base + $urandom_range(window);
         span = ($urandom_range(3) == 0) ? $urandom_range(65536 - lo) : $urandom_range(40);
         hi = lo + span;
         if (sel < 3) begin
            // Unused mode, and occasionally a reversed or empty range.
            pending_ops.push_back(make_op(2'd3, $urandom_range(65535), $urandom_range(65536)));
         end else if (sel < 8) begin
            pending_ops.push_back(make_op(($urandom_range(1) == 0) ? MODE_ADD : MODE_DEL,
                                          lo, $urandom_range(lo)));
         end else if (sel < 48) begin
            pending_ops.push_back(make_op(MODE_ADD, lo, hi));
         end else if (sel < 70) begin
            pending_ops.push_back(make_op(MODE_DEL, lo, hi));
         end else begin
            pending_ops.push_back(make_op(MODE_QUERY, lo, $urandom_range(131071)));
         end
      end
   endtask

   task automatic wait_drained();
      while (pending_ops.size() > 0 || start || expected_answers.size() > 0)
         @(posedge clock);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed part: empty and reversed ranges, extremes of the id space, touching
      // merges, a split, deletes of absent ids, the unused mode and queries past the set.
      pending_ops.push_back(make_op(MODE_QUERY, 0, 0));
      pending_ops.push_back(make_op(MODE_ADD, 5, 5));
      pending_ops.push_back(make_op(MODE_DEL, 9, 3));
      pending_ops.push_back(make_op(MODE_ADD, 0, 65536));
      pending_ops.push_back(make_op(MODE_QUERY, 65535, 131071));
      pending_ops.push_back(make_op(MODE_DEL, 100, 200));
      pending_ops.push_back(make_op(MODE_QUERY, 150, 0));
      pending_ops.push_back(make_op(MODE_QUERY, 200, 0));
      pending_ops.push_back(make_op(MODE_DEL, 0, 65536));
      pending_ops.push_back(make_op(MODE_DEL, 10, 20));
      pending_ops.push_back(make_op(MODE_ADD, 10, 20));
      pending_ops.push_back(make_op(MODE_ADD, 20, 30));
      pending_ops.push_back(make_op(MODE_ADD, 40, 50));
      pending_ops.push_back(make_op(MODE_ADD, 5, 10));
      pending_ops.push_back(make_op(MODE_ADD, 25, 45));
      pending_ops.push_back(make_op(MODE_DEL, 60, 70));
      pending_ops.push_back(make_op(MODE_DEL, 15, 20));
      pending_ops.push_back(make_op(MODE_QUERY, 65535, 0));
      pending_ops.push_back(make_op(2'd3, 65535, 131071));
      pending_ops.push_back(make_op(MODE_ADD, 65535, 65536));
      // Fill the table with two-id ranges four apart, overflow it by an add, then trim one entry.
      for (int n = 0; n < NRANGE; n++)
         pending_ops.push_back(make_op(MODE_ADD, 1000 + 4 * n, 1002 + 4 * n));
      pending_ops.push_back(make_op(MODE_ADD, 900, 901));
      pending_ops.push_back(make_op(MODE_DEL, 1000, 1001));
      pending_ops.push_back(make_op(MODE_QUERY, 1001, 0));
      pending_ops.push_back(make_op(MODE_DEL, 0, 65536));
      queue_random(500);
      wait_drained();

      send_idle_pct = 51;
      queue_random(550);
      wait_drained();

      send_idle_pct = 0;
      queue_random(550);
      wait_drained();
      stimulus_done = 1'b1;
   end

   initial begin
      @(posedge stimulus_done);
      repeat (80) @(posedge clock);
      $display("Ran %0d transactions, %0d responses checked, across add, delete, query,",
               accepted_ops, answers_seen);
      $display("unused mode, empty ranges and table overflow at three sender idle rates.");
      if (error_count == 0 && expected_answers.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // Watchdog on the total run length.
   always @(posedge clock) begin
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("CHECK FAILED");
         $finish;
      end
   end
endmodule
`default_nettype wire
